// ----- src/brfo_pkg.sv -----
// ----------------------------------------------------------------------------
// brfo_pkg
// Shared types and constants of the byte ring FIFO with overwrite: operation
// codes, request and response payloads, and the control and status bundles
// passed between the position tracker and the top level.
// ----------------------------------------------------------------------------
package brfo_pkg;

   // default number of byte slots in the store
   localparam int DEPTH_DEF = 256;

   // width of the capacity register and of the fill level
   localparam int CAP_BITS = 9;

   // byte operations
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FORCE = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // one request
   typedef struct packed {
      op_type      opcode;
      logic [7:0]  data_in;
      logic        burst_last;
   } req_type;

   // one response
   typedef struct packed {
      logic [7:0]          data_out;
      logic                done_res;
      logic                overwrote;
      logic [CAP_BITS-1:0] fill_level;
      logic                burst_last_out;
   } rsp_type;

   // command from the top level to the position tracker
   typedef struct packed {
      logic   exec;
      op_type opcode;
   } cmd_type;

   // outcome of the current command, seen by the top level
   typedef struct packed {
      logic                store_en;
      logic                load_en;
      logic                done;
      logic                overwrote;
      logic [CAP_BITS-1:0] fill_level;
   } stat_type;

endpackage

// ----- src/brfo_store.sv -----
// ----------------------------------------------------------------------------
// brfo_store
// Byte store of the ring: one write port and one read port, read data
// registered in the cycle after the read enable.
// ----------------------------------------------------------------------------
module brfo_store #(
   parameter int DEPTH = brfo_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/brfo_ptr.sv -----
// ----------------------------------------------------------------------------
// brfo_ptr
// Read and write positions with their wrap bits and the capacity register.
// Decides what the current command does to the store and updates the
// positions; reports the fill level after the command.
// ----------------------------------------------------------------------------
module brfo_ptr #(
   parameter int DEPTH = brfo_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  brfo_pkg::cmd_type             cmd,
   input  logic                          csr_fire,
   input  logic [brfo_pkg::CAP_BITS-1:0] csr_data,
   output logic [AW-1:0]                 wr_addr,
   output logic [AW-1:0]                 rd_addr,
   output brfo_pkg::stat_type            stat
);

   localparam int CW        = brfo_pkg::CAP_BITS;
   localparam int CAP_MAX   = (DEPTH < 511) ? DEPTH : 511;
   localparam int CAP_RESET = (DEPTH < 256) ? DEPTH : 256;
   localparam logic [CW-1:0] CAP_MAX_V   = CW'(CAP_MAX);
   localparam logic [CW-1:0] CAP_RESET_V = CW'(CAP_RESET);

   logic [AW-1:0] rp_ff, wp_ff;
   logic          rw_ff, ww_ff;
   logic [CW-1:0] cap_ff;

   logic [CW-1:0] rp9, wp9;
   logic [CW-1:0] rp9_in, wp9_in, cap_in, csr_cap;
   logic          rw_in, ww_in;
   logic [CW-1:0] fill_now;
   logic          full, empty;
   logic          store, load, done, over;

   // bytes held for a given pair of positions
   function automatic logic [CW-1:0] fill_of(input logic [CW-1:0] rp, input logic rw,
                                             input logic [CW-1:0] wp, input logic ww,
                                             input logic [CW-1:0] cap);
      logic [CW-1:0] f;
      if (rp == wp) begin
         f = (rw == ww) ? '0 : cap;
      end else if (wp > rp) begin
         f = wp - rp;
      end else begin
         f = cap - rp + wp;
      end
      return f;
   endfunction

   // step a position by one slot, toggling its wrap bit at the ring end
   function automatic logic [CW:0] step(input logic [CW-1:0] pos, input logic wrap,
                                        input logic [CW-1:0] cap);
      logic [CW-1:0] nxt;
      logic [CW:0]   r;
      nxt = pos + CW'(1);
      if (nxt >= cap) begin
         r = {~wrap, CW'(0)};
      end else begin
         r = {wrap, nxt};
      end
      return r;
   endfunction

   assign rp9 = CW'(rp_ff);
   assign wp9 = CW'(wp_ff);

   assign fill_now = fill_of(rp9, rw_ff, wp9, ww_ff, cap_ff);
   assign full     = (fill_now >= cap_ff);
   assign empty    = (fill_now == '0);

   // clamp a capacity write into the legal range
   always_comb begin
      csr_cap = (csr_data == '0) ? CW'(1) : csr_data;
      if (csr_cap > CAP_MAX_V) begin
         csr_cap = CAP_MAX_V;
      end
   end

   // next positions for the current command
   always_comb begin
      rp9_in = rp9;
      wp9_in = wp9;
      rw_in  = rw_ff;
      ww_in  = ww_ff;
      cap_in = cap_ff;
      store  = 1'b0;
      load   = 1'b0;
      done   = 1'b0;
      over   = 1'b0;
      unique case (cmd.opcode)
         brfo_pkg::OP_WRITE: begin
            if (!full) begin
               store           = 1'b1;
               done            = 1'b1;
               {ww_in, wp9_in} = step(wp9, ww_ff, cap_ff);
            end
         end
         brfo_pkg::OP_FORCE: begin
            store           = 1'b1;
            done            = 1'b1;
            {ww_in, wp9_in} = step(wp9, ww_ff, cap_ff);
            if (full) begin
               over            = 1'b1;
               {rw_in, rp9_in} = step(rp9, rw_ff, cap_ff);
            end
         end
         brfo_pkg::OP_READ: begin
            if (!empty) begin
               load            = 1'b1;
               done            = 1'b1;
               {rw_in, rp9_in} = step(rp9, rw_ff, cap_ff);
            end
         end
         brfo_pkg::OP_CLEAR: begin
            rp9_in = '0;
            wp9_in = '0;
            rw_in  = 1'b0;
            ww_in  = 1'b0;
         end
         default: begin
         end
      endcase
      // capacity write empties the ring
      if (csr_fire) begin
         cap_in = csr_cap;
         rp9_in = '0;
         wp9_in = '0;
         rw_in  = 1'b0;
         ww_in  = 1'b0;
      end
   end

   // position and capacity registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff  <= '0;
         wp_ff  <= '0;
         rw_ff  <= 1'b0;
         ww_ff  <= 1'b0;
         cap_ff <= CAP_RESET_V;
      end else if (cmd.exec || csr_fire) begin
         rp_ff  <= AW'(rp9_in);
         wp_ff  <= AW'(wp9_in);
         rw_ff  <= rw_in;
         ww_ff  <= ww_in;
         cap_ff <= cap_in;
      end
   end

   assign wr_addr         = wp_ff;
   assign rd_addr         = rp_ff;
   assign stat.store_en   = cmd.exec && store;
   assign stat.load_en    = cmd.exec && load;
   assign stat.done       = done;
   assign stat.overwrote  = over;
   assign stat.fill_level = fill_of(rp9_in, rw_in, wp9_in, ww_in, cap_in);

endmodule

// ----- src/byte_ring_fifo_with_overwrite_unit.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_overwrite_unit
// Byte FIFO over a ring in a synchronous store, with mirror-bit positions,
// forced write that drops the oldest byte, read, clear and a capacity
// register. One response per request, each reporting the fill level.
// ----------------------------------------------------------------------------
// Each request is one byte operation and gives exactly one response, which for
// write, forced write and clear is registered in the cycle after acceptance, so
// these run at one request per cycle when the response side keeps up. A read
// passes through the store's registered read port and the ST_READ state before
// it answers, and no request is taken while that read is under way. A new
// request is taken in the cycle its predecessor's response leaves the output
// register. The store is not cleared after reset; the positions start empty, so
// no clearing pass is needed and requests are taken right out of reset. A
// capacity write (taken only while no read is under way) empties the FIFO;
// values of 0 count as 1 and values above DEPTH count as DEPTH.
module byte_ring_fifo_with_overwrite_unit #(
   parameter int DEPTH = brfo_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  brfo_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output brfo_pkg::rsp_type             rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [brfo_pkg::CAP_BITS-1:0] csr_data
);

   localparam int AW = $clog2(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   brfo_pkg::rsp_type  rsp_ff, rsp_in;

   logic               accept;
   logic               csr_fire;
   brfo_pkg::cmd_type  cmd;
   brfo_pkg::stat_type stat;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [7:0]         rd_data;

   // handshakes
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_fire  = csr_valid && csr_ready;

   assign cmd.exec   = accept;
   assign cmd.opcode = req_payload.opcode;

   brfo_ptr #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ptr (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .csr_fire (csr_fire),
      .csr_data (csr_data),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .stat     (stat)
   );

   brfo_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (stat.store_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.data_in),
      .rd_en   (stat.load_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response sequencing
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.data_out       = '0;
               rsp_in.done_res       = stat.done;
               rsp_in.overwrote      = stat.overwrote;
               rsp_in.fill_level     = stat.fill_level;
               rsp_in.burst_last_out = req_payload.burst_last;
               if (stat.load_en) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            rsp_in.data_out = rd_data;
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and output register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // output register is free while a read is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("response pending during store read");

   // a request that needs no store read answers in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && !stat.load_en) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("non-read request did not answer next cycle");

   // a read request answers once the registered store read has passed through ST_READ
   assert property (@(posedge clock) disable iff (reset)
      (accept && stat.load_en) |=> ##1 rsp_valid_ff)
      else $error("read request did not answer after store latency");

   // nothing read means a zero byte, and an overwrite is always a store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.done_res || rsp_ff.data_out == 8'd0)
                        && (!rsp_ff.overwrote || rsp_ff.done_res)))
      else $error("inconsistent response flags");
`endif

endmodule
